[rtl/trmeu_pkg.sv]
package trmeu_pkg;

  localparam int MEM_WORDS = 1024;
  localparam int NUM_REGS  = 8;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int REG_AW    = $clog2(NUM_REGS);
  localparam int MEM_CW    = $clog2(MEM_WORDS + 1);

  typedef enum logic [3:0] {
    OP_NOP = 4'd0,
    OP_LDR = 4'd1,
    OP_STO = 4'd2,
    OP_ADD = 4'd3,
    OP_SUB = 4'd4,
    OP_MUL = 4'd5,
    OP_DIV = 4'd6,
    OP_INV = 4'd7,
    OP_OUT = 4'd8,
    OP_JNZ = 4'd9
  } op_t;

  localparam logic [1:0] KIND_MEM = 2'd0;
  localparam logic [1:0] KIND_REG = 2'd1;

  typedef enum logic [2:0] {
    ALU_NONE,
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_sts_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_DEST,
    ST_RD_SRC,
    ST_WAIT_RD,
    ST_EXEC,
    ST_ALU,
    ST_WRITE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [1:0]  dest_kind;
    logic [31:0] dest_value;
    logic [1:0]  src_kind;
    logic [31:0] src_value;
    logic [31:0] input_word;
  } in_item_t;

  typedef struct packed {
    logic        out_valid;
    logic [31:0] out_word;
    logic        jump_taken;
    logic [31:0] jump_target;
    logic        divide_error;
  } out_item_t;

endpackage

[rtl/trmeu_if.sv]
interface trmeu_in_if (input logic clk);
  logic                valid;
  logic                ready;
  trmeu_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trmeu_out_if (input logic clk);
  logic                 valid;
  logic                 ready;
  trmeu_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/tiny_register_memory_execute_unit.sv]
// Executes one decoded instruction per item against eight registers and a
// 1024-word data memory, returning one result item per input item. After
// reset a clearing pass zeroes the memory, one word a cycle, during which no
// item is accepted. An item passes through a dest and a src read through the
// single memory port with a wait state each, execute, write back, result and
// idle. add, sub, mul and a div by zero pass through an extra state in the
// shared arithmetic unit, and a div with a nonzero divisor also runs the
// bit-serial divider. The input is ready only while no item is in work.
module tiny_register_memory_execute_unit (
  input logic clk,
  input logic rst_n,
  trmeu_in_if.sink    in_ch,
  trmeu_out_if.source out_ch
);

  trmeu_pkg::state_t state_r, state_nxt;
  trmeu_pkg::in_item_t item_r, item_nxt;
  logic [31:0] d_r, d_nxt;
  logic [31:0] s_r, s_nxt;
  logic        rd_dest_r, rd_dest_nxt;
  logic [trmeu_pkg::MEM_CW-1:0] clr_r, clr_nxt;
  trmeu_pkg::out_item_t res_r, res_nxt;
  logic [31:0] wdata_r, wdata_nxt;
  logic        wen_r, wen_nxt;

  logic [31:0] regs_r [trmeu_pkg::NUM_REGS];
  logic [31:0] mem [trmeu_pkg::MEM_WORDS];
  logic [31:0] mem_q;
  logic        mem_we;
  logic [trmeu_pkg::MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata;

  trmeu_pkg::alu_ctl_t alu_ctl;
  trmeu_pkg::alu_sts_t alu_sts;
  logic [31:0] alu_res;

  logic dest_mem_ok, src_mem_ok, dest_reg_ok, src_reg_ok;
  logic [31:0] dest_reg_val, src_reg_val;
  logic [1:0]  wkind;

  assign dest_mem_ok = item_r.dest_value < 32'(trmeu_pkg::MEM_WORDS);
  assign src_mem_ok  = item_r.src_value < 32'(trmeu_pkg::MEM_WORDS);
  assign dest_reg_ok = item_r.dest_value < 32'(trmeu_pkg::NUM_REGS);
  assign src_reg_ok  = item_r.src_value < 32'(trmeu_pkg::NUM_REGS);
  assign dest_reg_val = dest_reg_ok ?
      regs_r[item_r.dest_value[trmeu_pkg::REG_AW-1:0]] : 32'd0;
  assign src_reg_val = src_reg_ok ?
      regs_r[item_r.src_value[trmeu_pkg::REG_AW-1:0]] : 32'd0;
  assign wkind = (item_r.op == 4'(trmeu_pkg::OP_LDR)) ? trmeu_pkg::KIND_REG
                                                       : item_r.dest_kind;

  trmeu_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (alu_ctl),
    .a      (d_r),
    .b      (s_r),
    .sts    (alu_sts),
    .result (alu_res)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    d_nxt       = d_r;
    s_nxt       = s_r;
    rd_dest_nxt = rd_dest_r;
    clr_nxt     = clr_r;
    res_nxt     = res_r;
    wdata_nxt   = wdata_r;
    wen_nxt     = wen_r;
    alu_ctl.start = 1'b0;
    alu_ctl.op    = trmeu_pkg::ALU_NONE;
    mem_we    = 1'b0;
    mem_waddr = item_r.dest_value[trmeu_pkg::MEM_AW-1:0];
    mem_wdata = wdata_r;
    mem_raddr = rd_dest_r ? item_r.dest_value[trmeu_pkg::MEM_AW-1:0]
                          : item_r.src_value[trmeu_pkg::MEM_AW-1:0];
    in_ch.ready = 1'b0;
    case (state_r)
      trmeu_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r[trmeu_pkg::MEM_AW-1:0];
        mem_wdata = 32'd0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == trmeu_pkg::MEM_CW'(trmeu_pkg::MEM_WORDS - 1)) begin
          state_nxt = trmeu_pkg::ST_IDLE;
        end
      end
      trmeu_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          item_nxt  = in_ch.data;
          state_nxt = trmeu_pkg::ST_RD_DEST;
        end
      end
      trmeu_pkg::ST_RD_DEST: begin
        // register and immediate operands resolve here, memory via read port
        case (item_r.dest_kind)
          trmeu_pkg::KIND_MEM: d_nxt = 32'd0;
          trmeu_pkg::KIND_REG: d_nxt = dest_reg_val;
          default:             d_nxt = item_r.dest_value;
        endcase
        rd_dest_nxt = 1'b1;
        state_nxt   = trmeu_pkg::ST_WAIT_RD;
      end
      trmeu_pkg::ST_WAIT_RD: begin
        // the read address is applied in this state; mem_q registers its data for ST_RD_SRC
        state_nxt = trmeu_pkg::ST_RD_SRC;
      end
      trmeu_pkg::ST_RD_SRC: begin
        if (rd_dest_r) begin
          if (item_r.dest_kind == trmeu_pkg::KIND_MEM && dest_mem_ok) begin
            d_nxt = mem_q;
          end
          rd_dest_nxt = 1'b0;
          state_nxt   = trmeu_pkg::ST_WAIT_RD;
          case (item_r.src_kind)
            trmeu_pkg::KIND_MEM: s_nxt = 32'd0;
            trmeu_pkg::KIND_REG: s_nxt = src_reg_val;
            default:             s_nxt = item_r.src_value;
          endcase
        end else begin
          if (item_r.src_kind == trmeu_pkg::KIND_MEM && src_mem_ok) begin
            s_nxt = mem_q;
          end
          state_nxt = trmeu_pkg::ST_EXEC;
        end
      end
      trmeu_pkg::ST_EXEC: begin
        res_nxt   = '0;
        wen_nxt   = 1'b0;
        wdata_nxt = s_r;
        state_nxt = trmeu_pkg::ST_WRITE;
        case (item_r.op)
          4'(trmeu_pkg::OP_LDR), 4'(trmeu_pkg::OP_STO): wen_nxt = 1'b1;
          4'(trmeu_pkg::OP_INV): begin
            wen_nxt   = 1'b1;
            wdata_nxt = item_r.input_word;
          end
          4'(trmeu_pkg::OP_ADD), 4'(trmeu_pkg::OP_SUB),
          4'(trmeu_pkg::OP_MUL), 4'(trmeu_pkg::OP_DIV): begin
            alu_ctl.start = 1'b1;
            case (item_r.op)
              4'(trmeu_pkg::OP_ADD): alu_ctl.op = trmeu_pkg::ALU_ADD;
              4'(trmeu_pkg::OP_SUB): alu_ctl.op = trmeu_pkg::ALU_SUB;
              4'(trmeu_pkg::OP_MUL): alu_ctl.op = trmeu_pkg::ALU_MUL;
              default:               alu_ctl.op = trmeu_pkg::ALU_DIV;
            endcase
            state_nxt = trmeu_pkg::ST_ALU;
          end
          4'(trmeu_pkg::OP_OUT): begin
            res_nxt.out_valid = 1'b1;
            res_nxt.out_word  = d_r;
          end
          4'(trmeu_pkg::OP_JNZ): begin
            if (d_r != 32'd0) begin
              res_nxt.jump_taken  = 1'b1;
              res_nxt.jump_target = s_r;
            end
          end
          default: ;
        endcase
      end
      trmeu_pkg::ST_ALU: begin
        if (alu_sts.done) begin
          res_nxt.divide_error = alu_sts.div_zero;
          wen_nxt   = !alu_sts.div_zero;
          wdata_nxt = alu_res;
          state_nxt = trmeu_pkg::ST_WRITE;
        end
      end
      trmeu_pkg::ST_WRITE: begin
        if (wen_r && wkind == trmeu_pkg::KIND_MEM && dest_mem_ok) begin
          mem_we = 1'b1;
        end
        state_nxt = trmeu_pkg::ST_RESULT;
      end
      trmeu_pkg::ST_RESULT: begin
        if (out_ch.ready) begin
          state_nxt = trmeu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = trmeu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trmeu_pkg::ST_CLEAR;
      clr_r   <= '0;
      wen_r   <= 1'b0;
      for (int i = 0; i < trmeu_pkg::NUM_REGS; i++) begin
        regs_r[i] <= 32'd0;
      end
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      wen_r   <= wen_nxt;
      if (state_r == trmeu_pkg::ST_WRITE && wen_r &&
          wkind == trmeu_pkg::KIND_REG && dest_reg_ok) begin
        regs_r[item_r.dest_value[trmeu_pkg::REG_AW-1:0]] <= wdata_r;
      end
    end
    item_r    <= item_nxt;
    d_r       <= d_nxt;
    s_r       <= s_nxt;
    rd_dest_r <= rd_dest_nxt;
    res_r     <= res_nxt;
    wdata_r   <= wdata_nxt;
  end

  assign out_ch.valid = (state_r == trmeu_pkg::ST_RESULT);
  assign out_ch.data  = res_r;

endmodule

[rtl/trmeu_alu.sv]
module trmeu_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  trmeu_pkg::alu_ctl_t ctl,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  output trmeu_pkg::alu_sts_t sts,
  output logic [31:0]         result
);

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic        dz_r, dz_nxt;
  logic [31:0] res_r, res_nxt;
  logic [31:0] ma, mb;
  logic [32:0] trial;
  logic [63:0] prod;

  assign ma    = a[31] ? (32'd0 - a) : a;
  assign mb    = b[31] ? (32'd0 - b) : b;
  assign trial = {rem_r[31:0], q_r[31]} - {1'b0, dvs_r};
  assign prod  = a * b;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    dz_nxt   = 1'b0;
    res_nxt  = res_r;
    if (ctl.start) begin
      case (ctl.op)
        trmeu_pkg::ALU_ADD: begin
          res_nxt  = a + b;
          done_nxt = 1'b1;
        end
        trmeu_pkg::ALU_SUB: begin
          res_nxt  = a - b;
          done_nxt = 1'b1;
        end
        trmeu_pkg::ALU_MUL: begin
          res_nxt  = prod[31:0];
          done_nxt = 1'b1;
        end
        trmeu_pkg::ALU_DIV: begin
          if (b == 32'd0) begin
            dz_nxt   = 1'b1;
            done_nxt = 1'b1;
          end else begin
            busy_nxt = 1'b1;
            cnt_nxt  = 6'd32;
            q_nxt    = ma;
            rem_nxt  = 33'd0;
            dvs_nxt  = mb;
            neg_nxt  = a[31] ^ b[31];
          end
        end
        default: done_nxt = 1'b1;
      endcase
    end else if (busy_r) begin
      // restoring division, one quotient bit per cycle
      if (cnt_r != 6'd0) begin
        if (!trial[32]) begin
          rem_nxt = trial;
          q_nxt   = {q_r[30:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[31:0], q_r[31]};
          q_nxt   = {q_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
      end else begin
        res_nxt  = neg_r ? (32'd0 - q_r) : q_r;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      dz_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      dz_r   <= dz_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign sts.done     = done_r;
  assign sts.div_zero = dz_r;
  assign result       = res_r;

endmodule

[rtl/trmeu_checker.sv]
module trmeu_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input trmeu_pkg::out_item_t out_data
);

  // one item in work at a time: never ready while a result is shown
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result too early");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped while stalled");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.out_valid) |-> out_data.out_word == 32'd0)
    else $error("out_word set without out_valid");

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_data.out_valid, out_data.jump_taken,
                            out_data.divide_error}))
    else $error("conflicting result flags");

endmodule

bind tiny_register_memory_execute_unit trmeu_checker u_trmeu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

[tb/tiny_register_memory_execute_unit_tb.sv]
`timescale 1ns / 1ps

module tiny_register_memory_execute_unit_tb;

  localparam logic [1:0] K_MEM = trmeu_pkg::KIND_MEM;
  localparam logic [1:0] K_REG = trmeu_pkg::KIND_REG;
  localparam logic [1:0] KIND_IMM = 2'd2;
  localparam int IDLE_LIMIT = 6000;
  localparam int HOLD_CYCLES = 300;

  class exec_scoreboard;
    logic [31:0] regs[trmeu_pkg::NUM_REGS];
    logic [31:0] mem[trmeu_pkg::MEM_WORDS];
    trmeu_pkg::out_item_t pending[$];
    int errors;
    int checked;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      errors = 0;
      checked = 0;
    endfunction

    function logic [31:0] fetch(logic [1:0] kind, logic [31:0] v);
      if (kind == K_MEM) return (v < trmeu_pkg::MEM_WORDS) ? mem[v] : '0;
      if (kind == K_REG) return (v < trmeu_pkg::NUM_REGS) ? regs[v] : '0;
      return v;
    endfunction

    function void put(logic [1:0] kind, logic [31:0] v, logic [31:0] d);
      if (kind == K_MEM) begin
        if (v < trmeu_pkg::MEM_WORDS) mem[v] = d;
      end else if (kind == K_REG) begin
        if (v < trmeu_pkg::NUM_REGS) regs[v] = d;
      end
    endfunction

    function logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] != b[31]) ? -q : q;
    endfunction

    function void note_input(trmeu_pkg::in_item_t it);
      logic [31:0] d, s;
      trmeu_pkg::out_item_t r;
      d = fetch(it.dest_kind, it.dest_value);
      s = fetch(it.src_kind, it.src_value);
      r = '0;
      case (it.op)
        trmeu_pkg::OP_LDR: put(K_REG, it.dest_value, s);
        trmeu_pkg::OP_STO: put(it.dest_kind, it.dest_value, s);
        trmeu_pkg::OP_ADD: put(it.dest_kind, it.dest_value, d + s);
        trmeu_pkg::OP_SUB: put(it.dest_kind, it.dest_value, d - s);
        trmeu_pkg::OP_MUL: put(it.dest_kind, it.dest_value, d * s);
        trmeu_pkg::OP_DIV: begin
          if (s == 0) r.divide_error = 1'b1;
          else put(it.dest_kind, it.dest_value, quotient(d, s));
        end
        trmeu_pkg::OP_INV: put(it.dest_kind, it.dest_value, it.input_word);
        trmeu_pkg::OP_OUT: begin
          r.out_valid = 1'b1;
          r.out_word = d;
        end
        trmeu_pkg::OP_JNZ: begin
          if (d != 0) begin
            r.jump_taken = 1'b1;
            r.jump_target = s;
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(trmeu_pkg::out_item_t got);
      trmeu_pkg::out_item_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.out_valid !== exp.out_valid)
        $display("%0t: out_valid exp %b got %b", $time, exp.out_valid, got.out_valid);
      if (got.out_word !== exp.out_word)
        $display("%0t: out_word exp %h got %h", $time, exp.out_word, got.out_word);
      if (got.jump_taken !== exp.jump_taken)
        $display("%0t: jump_taken exp %b got %b", $time, exp.jump_taken, got.jump_taken);
      if (got.jump_target !== exp.jump_target)
        $display("%0t: jump_target exp %h got %h", $time, exp.jump_target,
                 got.jump_target);
      if (got.divide_error !== exp.divide_error)
        $display("%0t: divide_error exp %b got %b", $time, exp.divide_error,
                 got.divide_error);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  trmeu_in_if in_ch (clk);
  trmeu_out_if out_ch (clk);

  tiny_register_memory_execute_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  exec_scoreboard sb;
  trmeu_pkg::in_item_t program_q[$];
  bit calm;
  bit hold_out;
  int idle_cycles;
  int sent;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] pick_value(logic [1:0] kind);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return {1'b1, 31'($urandom)};
      2: return 32'($urandom_range(trmeu_pkg::MEM_WORDS, trmeu_pkg::MEM_WORDS + 4));
      default: begin
        if (kind == K_MEM) return 32'($urandom_range(0, 15));
        if (kind == K_REG) return 32'($urandom_range(0, trmeu_pkg::NUM_REGS - 1));
        return (($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
      end
    endcase
  endfunction

  function automatic trmeu_pkg::in_item_t make_insn(logic [3:0] op, logic [1:0] dk,
                                                    logic [31:0] dv, logic [1:0] sk,
                                                    logic [31:0] sv, logic [31:0] w);
    trmeu_pkg::in_item_t it;
    it.op = op;
    it.dest_kind = dk;
    it.dest_value = dv;
    it.src_kind = sk;
    it.src_value = sv;
    it.input_word = w;
    return it;
  endfunction

  function automatic trmeu_pkg::in_item_t rand_insn();
    trmeu_pkg::in_item_t it;
    it.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(0, 9));
    it.dest_kind = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                               : 2'($urandom_range(0, 1));
    it.src_kind = 2'($urandom_range(0, 3));
    it.dest_value = pick_value(it.dest_kind);
    it.src_value = pick_value(it.src_kind);
    it.input_word = $urandom;
    return it;
  endfunction

  task automatic build_program();
    program_q.push_back(make_insn(trmeu_pkg::OP_INV, K_REG, 0, KIND_IMM, 0, 32'h8000_0000));
    program_q.push_back(make_insn(trmeu_pkg::OP_INV, K_MEM, 1023, KIND_IMM, 0, 32'h7fff_ffff));
    program_q.push_back(make_insn(trmeu_pkg::OP_OUT, K_MEM, 1023, KIND_IMM, 0, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_LDR, K_MEM, 1, KIND_IMM, 32'hffff_ffff, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_DIV, K_REG, 0, K_REG, 1, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_OUT, K_REG, 0, KIND_IMM, 0, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_DIV, K_REG, 0, KIND_IMM, 0, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_STO, K_MEM, 5, KIND_IMM, 32'hffff_fff9, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_DIV, K_MEM, 5, KIND_IMM, 2, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_OUT, K_MEM, 5, KIND_IMM, 0, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_ADD, K_MEM, 1023, KIND_IMM, 1, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_SUB, K_REG, 1, K_MEM, 1023, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_MUL, K_REG, 1, K_REG, 1, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_OUT, K_REG, 1, KIND_IMM, 0, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_STO, KIND_IMM, 3, KIND_IMM, 9, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_STO, K_MEM, 1024, KIND_IMM, 9, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_STO, K_REG, 8, KIND_IMM, 9, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_OUT, K_MEM, 32'hffff_ffff, K_REG, 0, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_JNZ, K_REG, 0, KIND_IMM, 32'h1234_5678, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_JNZ, K_REG, 8, KIND_IMM, 77, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_JNZ, 2'd3, 1, 2'd3, 32'hdead_beef, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_NOP, K_REG, 0, KIND_IMM, 0, 0));
    program_q.push_back(make_insn(4'd15, K_REG, 0, KIND_IMM, 1, 0));
    program_q.push_back(make_insn(trmeu_pkg::OP_OUT, K_REG, 0, KIND_IMM, 0, 0));
    repeat (450) program_q.push_back(rand_insn());
  endtask

  task automatic send_all();
    trmeu_pkg::in_item_t it;
    while (program_q.size() > 0) begin
      it = program_q.pop_front();
      while (!calm && $urandom_range(0, 99) < 35) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.data <= it;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      sb.note_input(it);
      sent++;
      @(negedge clk);
    end
    in_ch.valid <= 1'b0;
  endtask

  // receiver side: random stall plus a long hold-off
  always @(negedge clk) begin
    if (!rst_n || hold_out) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 35);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: stuck after %0d items", sent);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    wait (sent >= 60);
    @(negedge clk);
    hold_out = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_out = 1'b0;
  end

  initial begin
    sb = new();
    calm = 1'b0;
    hold_out = 1'b0;
    sent = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    build_program();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    fork
      send_all();
      begin
        wait (sent >= 200);
        calm = 1'b1;
        wait (sent >= 300);
        calm = 1'b0;
      end
    join
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("ran %0d instructions, %0d results checked, incl. div and out-of-range cases",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
